### rtl/rbf_pkg.sv
// Shared types and constants for the rectangle blitter write-back path.
package rbf_pkg;

    localparam int COORD_BITS_DEFAULT = 12;

    localparam int PIXEL_W    = 32;
    localparam int OP_MODE_W  = 2;
    localparam int ALPHA_W    = 8;
    localparam int CHAN_W     = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 3;

    // Operation codes
    localparam logic [OP_MODE_W-1:0] OP_FILL  = 2'd0;
    localparam logic [OP_MODE_W-1:0] OP_COPY  = 2'd1;
    localparam logic [OP_MODE_W-1:0] OP_BLEND = 2'd2;
    localparam logic [OP_MODE_W-1:0] OP_NONE  = 2'd3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_OP_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_ALPHA = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FILL_COLOR  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DST_STRIDE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DST_X       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DST_Y       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RECT_WIDTH  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_RECT_HEIGHT = 3'd7;

    localparam logic [ALPHA_W-1:0] FULL_ALPHA  = 8'd255;
    localparam logic [ALPHA_W-1:0] ZERO_ALPHA  = 8'd0;
    localparam logic [CHAN_W-1:0]  OPAQUE_BYTE = 8'hFF;

    typedef struct packed {
        logic [OP_MODE_W-1:0] op_mode;
        logic [ALPHA_W-1:0]   blend_alpha;
        logic [PIXEL_W-1:0]   fill_color;
    } pix_cfg_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               write_enable;
    } pix_res_t;

endpackage

### rtl/rbf_pixel_unit.sv
// Per-pixel color path: fill, copy and constant-alpha blend.
module rbf_pixel_unit (
    input  rbf_pkg::pix_cfg_t              cfg,
    input  logic [rbf_pkg::PIXEL_W-1:0]    src_pixel,
    input  logic [rbf_pkg::PIXEL_W-1:0]    dst_pixel,
    output rbf_pkg::pix_res_t              res
);

    localparam int CW = rbf_pkg::CHAN_W;

    logic [CW-1:0]           dst_weight;
    logic [3*CW-1:0]         mixed;
    logic [rbf_pkg::PIXEL_W-1:0] blended;

    assign dst_weight = rbf_pkg::FULL_ALPHA - cfg.blend_alpha;

    // three channels, one 8x8 multiply pair each
    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [2*CW-1:0] prod_s;
        logic [2*CW-1:0] prod_d;
        logic [2*CW-1:0] sum;
        assign prod_s = src_pixel[c*CW +: CW] * cfg.blend_alpha;
        assign prod_d = dst_pixel[c*CW +: CW] * dst_weight;
        // s*a + d*(255-a) never exceeds 255*255, so 16 bits hold it
        assign sum    = prod_s + prod_d;
        assign mixed[c*CW +: CW] = sum[2*CW-1:CW];
    end

    assign blended = {rbf_pkg::OPAQUE_BYTE, mixed};

    always_comb begin
        res.pixel        = dst_pixel;
        res.write_enable = 1'b0;
        unique case (cfg.op_mode)
            rbf_pkg::OP_FILL: begin
                res.pixel        = cfg.fill_color;
                res.write_enable = 1'b1;
            end
            rbf_pkg::OP_COPY: begin
                res.pixel        = src_pixel;
                res.write_enable = 1'b1;
            end
            rbf_pkg::OP_BLEND: begin
                priority if (cfg.blend_alpha == rbf_pkg::FULL_ALPHA) begin
                    res.pixel        = src_pixel;
                    res.write_enable = 1'b1;
                end else if (cfg.blend_alpha != rbf_pkg::ZERO_ALPHA) begin
                    res.pixel        = blended;
                    res.write_enable = 1'b1;
                end else begin
                    res.pixel        = dst_pixel;
                    res.write_enable = 1'b0;
                end
            end
            rbf_pkg::OP_NONE: begin
                res.pixel        = dst_pixel;
                res.write_enable = 1'b0;
            end
            default: begin
                res.pixel        = dst_pixel;
                res.write_enable = 1'b0;
            end
        endcase
    end

endmodule

### rtl/rect_blitter_fill_copy_blend.sv
// Top level of the rectangle blitter write-back path (fill, copy, blend).
//
//  channel  | handshake          | word
//  ---------+--------------------+--------------------------------------------
//  input    | s_valid / s_ready  | s_src_pixel, s_dst_pixel
//  result   | m_valid / m_ready  | m_pixel_out, m_dst_offset, m_write_enable,
//           |                    | m_last_pixel
//  config   | cfg_wen            | cfg_index, cfg_wdata (no read-back)
//
// One word per clock sustained while m_ready is high; each word passes
// through two registers: an input register, then the color mix and the
// offset multiply feeding the result register.
// aresetn is synchronous, active low; it resets the configuration registers
// (op mode to fill, alpha to 255, the rest to zero), the rectangle counters and both valid flags.
// A stall on m_ready holds the result register; the input register keeps
// taking a word as long as it can move on, so s_ready drops only when both
// stages are full.
module rect_blitter_fill_copy_blend #(
    parameter int COORD_BITS = rbf_pkg::COORD_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wen,
    input  logic [rbf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rbf_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rbf_pkg::PIXEL_W-1:0]       s_src_pixel,
    input  logic [rbf_pkg::PIXEL_W-1:0]       s_dst_pixel,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rbf_pkg::PIXEL_W-1:0]       m_pixel_out,
    output logic [2*COORD_BITS:0]             m_dst_offset,
    output logic                              m_write_enable,
    output logic                              m_last_pixel
);

    localparam int CB     = COORD_BITS;
    localparam int OFFS_W = 2 * COORD_BITS + 1;
    localparam int PW     = rbf_pkg::PIXEL_W;

    // ---------------- configuration registers ----------------
    logic [rbf_pkg::OP_MODE_W-1:0] op_mode_reg;
    logic [rbf_pkg::ALPHA_W-1:0]   blend_alpha_reg;
    logic [PW-1:0]                 fill_color_reg;
    logic [CB-1:0]                 dst_stride_reg;
    logic [CB-1:0]                 dst_x_reg;
    logic [CB-1:0]                 dst_y_reg;
    logic [CB-1:0]                 rect_width_reg;
    logic [CB-1:0]                 rect_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg     <= rbf_pkg::OP_FILL;
            blend_alpha_reg <= rbf_pkg::FULL_ALPHA;
            fill_color_reg  <= '0;
            dst_stride_reg  <= '0;
            dst_x_reg       <= '0;
            dst_y_reg       <= '0;
            rect_width_reg  <= '0;
            rect_height_reg <= '0;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                rbf_pkg::REG_OP_MODE:     op_mode_reg     <= cfg_wdata[rbf_pkg::OP_MODE_W-1:0];
                rbf_pkg::REG_BLEND_ALPHA: blend_alpha_reg <= cfg_wdata[rbf_pkg::ALPHA_W-1:0];
                rbf_pkg::REG_FILL_COLOR:  fill_color_reg  <= cfg_wdata[PW-1:0];
                rbf_pkg::REG_DST_STRIDE:  dst_stride_reg  <= cfg_wdata[CB-1:0];
                rbf_pkg::REG_DST_X:       dst_x_reg       <= cfg_wdata[CB-1:0];
                rbf_pkg::REG_DST_Y:       dst_y_reg       <= cfg_wdata[CB-1:0];
                rbf_pkg::REG_RECT_WIDTH:  rect_width_reg  <= cfg_wdata[CB-1:0];
                rbf_pkg::REG_RECT_HEIGHT: rect_height_reg <= cfg_wdata[CB-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic st1_valid_reg;
    logic out_valid_reg;
    logic out_ready;
    logic st1_ready;
    logic s_accept;
    logic st1_adv;

    assign out_ready = !out_valid_reg || m_ready;
    assign st1_ready = !st1_valid_reg || out_ready;
    assign s_ready   = st1_ready;
    assign s_accept  = s_valid && st1_ready;
    assign st1_adv   = st1_valid_reg && out_ready;

    // ---------------- rectangle walk ----------------
    logic [CB-1:0] col_reg, col_next;
    logic [CB-1:0] row_reg, row_next;
    logic          rect_empty;
    logic [CB:0]   col_inc;
    logic [CB:0]   row_inc;
    logic          last_col;
    logic          last_row;

    assign rect_empty = (rect_width_reg == '0) || (rect_height_reg == '0);
    assign col_inc    = {1'b0, col_reg} + {{CB{1'b0}}, 1'b1};
    assign row_inc    = {1'b0, row_reg} + {{CB{1'b0}}, 1'b1};
    // a counter left past its bound by a register change also counts as last
    assign last_col   = col_inc >= {1'b0, rect_width_reg};
    assign last_row   = row_inc >= {1'b0, rect_height_reg};

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (rect_empty) begin
            col_next = '0;
            row_next = '0;
        end else if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_inc[CB-1:0];
        end else begin
            col_next = col_inc[CB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- input register ----------------
    logic [PW-1:0] st1_src_reg;
    logic [PW-1:0] st1_dst_reg;
    logic [CB-1:0] st1_col_reg;
    logic [CB-1:0] st1_row_reg;
    logic          st1_empty_reg;
    logic          st1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (st1_ready) begin
            st1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_src_reg   <= s_src_pixel;
            st1_dst_reg   <= s_dst_pixel;
            st1_col_reg   <= col_reg;
            st1_row_reg   <= row_reg;
            st1_empty_reg <= rect_empty;
            st1_last_reg  <= last_col && last_row;
        end
    end

    // ---------------- color and address ----------------
    rbf_pkg::pix_cfg_t pix_cfg;
    rbf_pkg::pix_res_t pix_res;

    assign pix_cfg.op_mode     = op_mode_reg;
    assign pix_cfg.blend_alpha = blend_alpha_reg;
    assign pix_cfg.fill_color  = fill_color_reg;

    rbf_pixel_unit u_pixel (
        .cfg       (pix_cfg),
        .src_pixel (st1_src_reg),
        .dst_pixel (st1_dst_reg),
        .res       (pix_res)
    );

    // (dst_y + row) * stride + dst_x + col, kept to the offset width
    logic [CB:0]       y_abs;
    logic [CB:0]       x_abs;
    logic [OFFS_W-1:0] row_base;
    logic [OFFS_W:0]   offs_sum;

    assign y_abs    = {1'b0, dst_y_reg} + {1'b0, st1_row_reg};
    assign x_abs    = {1'b0, dst_x_reg} + {1'b0, st1_col_reg};
    assign row_base = y_abs * dst_stride_reg;
    assign offs_sum = {1'b0, row_base} + {{(OFFS_W-CB){1'b0}}, x_abs};

    // ---------------- result register ----------------
    logic [PW-1:0]     out_pixel_reg,  out_pixel_next;
    logic [OFFS_W-1:0] out_offset_reg, out_offset_next;
    logic              out_we_reg,     out_we_next;
    logic              out_last_reg,   out_last_next;

    always_comb begin
        if (st1_empty_reg) begin
            out_pixel_next  = st1_dst_reg;
            out_offset_next = '0;
            out_we_next     = 1'b0;
            out_last_next   = 1'b0;
        end else begin
            out_pixel_next  = pix_res.pixel;
            out_offset_next = offs_sum[OFFS_W-1:0];
            out_we_next     = pix_res.write_enable;
            out_last_next   = st1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv) begin
            out_pixel_reg  <= out_pixel_next;
            out_offset_reg <= out_offset_next;
            out_we_reg     <= out_we_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_pixel_out    = out_pixel_reg;
    assign m_dst_offset   = out_offset_reg;
    assign m_write_enable = out_we_reg;
    assign m_last_pixel   = out_last_reg;

`ifndef SYNTHESIS
    // an empty rectangle parks both counters at zero
    a_empty_parks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !cfg_wen && rect_empty) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters not parked on empty rectangle");

    // after a pixel the column counter is back inside the rectangle
    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !cfg_wen && !rect_empty) |=> (col_reg < rect_width_reg))
        else $error("column counter past rectangle width");

    // a word whose pixel was suppressed for an empty rectangle carries no offset
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_adv && st1_empty_reg) |=> (!out_we_reg && !out_last_reg && out_offset_reg == '0))
        else $error("empty rectangle produced a write or an offset");
`endif

endmodule
